/* src/assert_macros.svh */
// Assertion macros used by the checker file of the row partition block.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define RPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("row partition check failed");

// Next-cycle implication, disabled while reset is asserted
`define RPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("row partition check failed");

`endif

/* src/rpt_pkg.sv */
// Package for the row partition block: field widths, operation and error codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package rpt_pkg;

	// Fixed field widths
	localparam int OP_W   = 2;
	localparam int ID_W   = 63;
	localparam int ROW_W  = 6;
	localparam int CHAN_W = 4;
	localparam int ERR_W  = 2;

	// Default sizes
	localparam int MAX_TABLETS_DEF = 16;
	localparam int MAX_ROWS_DEF    = 64;

	// Operation codes
	localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
	localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
	localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

	// Error codes
	localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
	localparam logic [ERR_W-1:0] ERR_UNKNOWN   = 2'd1;
	localparam logic [ERR_W-1:0] ERR_ROWS_FULL = 2'd2;
	localparam logic [ERR_W-1:0] ERR_TAB_FULL  = 2'd3;

	// Phases of the multi-cycle row and channel loops
	localparam logic [1:0] PH_A = 2'd0;
	localparam logic [1:0] PH_B = 2'd1;
	localparam logic [1:0] PH_C = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN_ADD,
		ST_SCAN_APP,
		ST_FIN,
		ST_CLEAR,
		ST_COUNT,
		ST_PREFIX,
		ST_SCATTER,
		ST_OUTPUT
	} state_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_ADD,
		CMD_APPEND,
		CMD_EMIT_ERR,
		CMD_DONE,
		CMD_FIN_INIT,
		CMD_CLEAR,
		CMD_COUNT,
		CMD_PREFIX,
		CMD_SCATTER,
		CMD_OUTPUT
	} cmd_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [1:0] ph;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic ch_last;
		logic idx_top;
		logic idx_zero;
		logic err_set;
		logic rows_zero;
	} dp_stat_t;

endpackage

/* src/row_partition_by_tablet.sv */
// Top level of the row partition block: controller plus datapath.
// Depends on rpt_pkg, rpt_ctrl and rpt_dp.
//
// Requests are taken when start is high and busy is low; the receiver cannot
// stall, so each result shows on the result ports for exactly one cycle with
// result_strobe high. An add or append request keeps busy high while the id
// is compared against the known table one entry a cycle through its single
// registered read port. A finish with a latched error, or with no rows,
// keeps busy high only in ST_FIN and gives one error result or nothing. A
// finish with rows keeps busy high through the deciding step, clearing the
// channel start table, counting per row, prefix sums per channel, scattering
// per row and emitting per row, each loop paced by the registered reads of
// the row store and the start table. The last row result is strobed in the
// same cycle that busy drops.
module row_partition_by_tablet #(
	parameter int MAX_TABLETS = rpt_pkg::MAX_TABLETS_DEF,
	parameter int MAX_ROWS    = rpt_pkg::MAX_ROWS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [rpt_pkg::OP_W-1:0]   operation,
	input  logic [rpt_pkg::ID_W-1:0]   tablet_key,
	output logic                       result_strobe,
	output logic                       row_valid,
	output logic [rpt_pkg::ROW_W-1:0]  row_index,
	output logic [rpt_pkg::CHAN_W-1:0] channel_rank,
	output logic [rpt_pkg::ERR_W-1:0]  error_code,
	output logic                       is_last
);
	import rpt_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Sequencer
	rpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.stat      (stat),
		.cmd       (cmd),
		.busy      (busy)
	);

	// Tables, counters and result registers
	rpt_dp #(
		.MAX_TABLETS (MAX_TABLETS),
		.MAX_ROWS    (MAX_ROWS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.tablet_key    (tablet_key),
		.cmd           (cmd),
		.stat          (stat),
		.result_strobe (result_strobe),
		.row_valid     (row_valid),
		.row_index     (row_index),
		.channel_rank  (channel_rank),
		.error_code    (error_code),
		.is_last       (is_last)
	);

endmodule

/* src/rpt_ctrl.sv */
// Controller of the row partition block: sequences the id lookup and the clear /
// count / prefix / scatter / output walk of a finish. Depends on rpt_pkg.
module rpt_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [rpt_pkg::OP_W-1:0] operation,
	input  rpt_pkg::dp_stat_t        stat,
	output rpt_pkg::dp_cmd_t         cmd,
	output logic                     busy
);
	import rpt_pkg::*;

	state_t     state_q, state_d;
	logic [1:0] ph_q, ph_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ph_q    <= PH_A;
		end else begin
			state_q <= state_d;
			ph_q    <= ph_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		ph_d    = ph_q;
		cmd.cmd = CMD_NONE;
		cmd.ph  = ph_q;
		busy    = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				ph_d = PH_A;
				if (start) begin
					unique case (operation)
						OP_ADD: begin
							cmd.cmd = CMD_LOAD;
							state_d = ST_SCAN_ADD;
						end
						OP_APPEND: begin
							cmd.cmd = CMD_LOAD;
							state_d = ST_SCAN_APP;
						end
						OP_FINISH: state_d = ST_FIN;
						default: ;
					endcase
				end
			end
			ST_SCAN_ADD: begin
				if (stat.scan_done) begin
					cmd.cmd = CMD_ADD;
					state_d = ST_IDLE;
				end
			end
			ST_SCAN_APP: begin
				if (stat.scan_done) begin
					cmd.cmd = CMD_APPEND;
					state_d = ST_IDLE;
				end
			end
			ST_FIN: begin
				priority if (stat.err_set) begin
					cmd.cmd = CMD_EMIT_ERR;
					state_d = ST_IDLE;
				end else if (stat.rows_zero) begin
					cmd.cmd = CMD_DONE;
					state_d = ST_IDLE;
				end else begin
					cmd.cmd = CMD_FIN_INIT;
					state_d = ST_CLEAR;
				end
			end
			ST_CLEAR: begin
				cmd.cmd = CMD_CLEAR;
				if (stat.ch_last) begin
					state_d = ST_COUNT;
				end
			end
			ST_COUNT: begin
				cmd.cmd = CMD_COUNT;
				if (ph_q == PH_C) begin
					ph_d = PH_A;
					if (stat.idx_top) state_d = ST_PREFIX;
				end else begin
					ph_d = ph_q + 2'd1;
				end
			end
			ST_PREFIX: begin
				cmd.cmd = CMD_PREFIX;
				if (ph_q == PH_B) begin
					ph_d = PH_A;
					if (stat.ch_last) state_d = ST_SCATTER;
				end else begin
					ph_d = PH_B;
				end
			end
			ST_SCATTER: begin
				cmd.cmd = CMD_SCATTER;
				if (ph_q == PH_C) begin
					ph_d = PH_A;
					if (stat.idx_zero) state_d = ST_OUTPUT;
				end else begin
					ph_d = ph_q + 2'd1;
				end
			end
			ST_OUTPUT: begin
				cmd.cmd = CMD_OUTPUT;
				if (ph_q == PH_C) begin
					ph_d = PH_A;
					if (stat.idx_top) state_d = ST_IDLE;
				end else begin
					ph_d = ph_q + 2'd1;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

/* src/rpt_dp.sv */
// Datapath of the row partition block: known-id table, row channel store,
// channel start table, ordered row list, loop counters and result registers.
// Depends on rpt_pkg.
module rpt_dp #(
	parameter int MAX_TABLETS = rpt_pkg::MAX_TABLETS_DEF,
	parameter int MAX_ROWS    = rpt_pkg::MAX_ROWS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [rpt_pkg::ID_W-1:0]   tablet_key,
	input  rpt_pkg::dp_cmd_t           cmd,
	output rpt_pkg::dp_stat_t          stat,
	output logic                       result_strobe,
	output logic                       row_valid,
	output logic [rpt_pkg::ROW_W-1:0]  row_index,
	output logic [rpt_pkg::CHAN_W-1:0] channel_rank,
	output logic [rpt_pkg::ERR_W-1:0]  error_code,
	output logic                       is_last
);
	import rpt_pkg::*;

	localparam int TW  = (MAX_TABLETS > 1) ? $clog2(MAX_TABLETS) : 1;
	localparam int KW  = $clog2(MAX_TABLETS + 1);
	localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int RCW = $clog2(MAX_ROWS + 1);

	// Memories
	logic [ID_W-1:0] kt_mem  [MAX_TABLETS];
	logic [TW-1:0]   rc_mem  [MAX_ROWS];
	logic [RCW-1:0]  st_mem  [MAX_TABLETS];
	logic [RIW-1:0]  ord_mem [MAX_ROWS];

	logic [ID_W-1:0] kt_rd_q;
	logic [TW-1:0]   rc_rd_q;
	logic [RCW-1:0]  st_rd_q;
	logic [RIW-1:0]  ord_rd_q;

	// Control registers
	logic [KW-1:0]    known_cnt_q;
	logic [RCW-1:0]   row_cnt_q;
	logic [ERR_W-1:0] err_q;
	logic [KW-1:0]    k_q;
	logic             v_s1;
	logic [KW-1:0]    ch_q;
	logic [RCW-1:0]   idx_q;
	logic             strobe_q;

	// Payload registers
	logic [ID_W-1:0]   id_q;
	logic [KW-1:0]     rank_q;
	logic              hit_q;
	logic [RCW-1:0]    acc_q;
	logic              row_valid_q;
	logic [ROW_W-1:0]  row_index_q;
	logic [CHAN_W-1:0] channel_rank_q;
	logic [ERR_W-1:0]  error_code_q;
	logic              is_last_q;

	// Combinational
	logic             scan_issue;
	logic             ch_last, idx_top, idx_zero;
	logic             add_new, rc_we, st_we, ord_we;
	logic [ERR_W-1:0] err_new;
	logic [RIW-1:0]   rc_ra;
	logic [TW-1:0]    st_ra, st_wa;
	logic [RCW-1:0]   st_wd, st_sum, st_dec;
	logic [TW-1:0]    rc_wd;
	logic             emit_row;

	assign scan_issue = (k_q < known_cnt_q);
	assign ch_last    = (ch_q == known_cnt_q - 1'b1);
	assign idx_top    = (idx_q == row_cnt_q - 1'b1);
	assign idx_zero   = (idx_q == '0);
	assign st_sum     = acc_q + st_rd_q;
	assign st_dec     = st_rd_q - 1'b1;
	assign emit_row   = (cmd.cmd == CMD_OUTPUT) && (cmd.ph == PH_C);

	assign stat.scan_done = !scan_issue && !v_s1;
	assign stat.ch_last   = ch_last;
	assign stat.idx_top   = idx_top;
	assign stat.idx_zero  = idx_zero;
	assign stat.err_set   = (err_q != ERR_NONE);
	assign stat.rows_zero = (row_cnt_q == '0);

	// Commit of add / append and error detection
	always_comb begin
		add_new = 1'b0;
		rc_we   = 1'b0;
		err_new = ERR_NONE;
		rc_wd   = hit_q ? rank_q[TW-1:0] : '0;
		if (cmd.cmd == CMD_ADD && !hit_q) begin
			if (known_cnt_q == KW'(MAX_TABLETS)) err_new = ERR_TAB_FULL;
			else                                 add_new = 1'b1;
		end
		if (cmd.cmd == CMD_APPEND) begin
			if (row_cnt_q == RCW'(MAX_ROWS)) begin
				err_new = ERR_ROWS_FULL;
			end else begin
				rc_we = 1'b1;
				if (!hit_q) err_new = ERR_UNKNOWN;
			end
		end
	end

	// Read address selection: row store by ordered row while emitting
	always_comb begin
		rc_ra = (cmd.cmd == CMD_OUTPUT) ? ord_rd_q : idx_q[RIW-1:0];
		st_ra = (cmd.cmd == CMD_PREFIX) ? ch_q[TW-1:0] : rc_rd_q;
	end

	// Start table write port
	always_comb begin
		st_we  = 1'b0;
		st_wa  = rc_rd_q;
		st_wd  = '0;
		ord_we = 1'b0;
		unique case (cmd.cmd)
			CMD_CLEAR: begin
				st_we = 1'b1;
				st_wa = ch_q[TW-1:0];
			end
			CMD_COUNT: begin
				st_we = (cmd.ph == PH_C);
				st_wd = st_rd_q + 1'b1;
			end
			CMD_PREFIX: begin
				st_we = (cmd.ph == PH_B);
				st_wa = ch_q[TW-1:0];
				st_wd = st_sum;
			end
			CMD_SCATTER: begin
				st_we  = (cmd.ph == PH_C);
				ord_we = (cmd.ph == PH_C);
				st_wd  = st_dec;
			end
			default: ;
		endcase
	end

	// Known-id table
	always_ff @(posedge clk) begin
		kt_rd_q <= kt_mem[k_q[TW-1:0]];
		if (add_new) kt_mem[known_cnt_q[TW-1:0]] <= id_q;
	end

	// Row channel store, read by row index or by ordered row
	always_ff @(posedge clk) begin
		rc_rd_q <= rc_mem[rc_ra];
		if (rc_we) rc_mem[row_cnt_q[RIW-1:0]] <= rc_wd;
	end

	// Channel start table
	always_ff @(posedge clk) begin
		st_rd_q <= st_mem[st_ra];
		if (st_we) st_mem[st_wa] <= st_wd;
	end

	// Ordered row list
	always_ff @(posedge clk) begin
		ord_rd_q <= ord_mem[idx_q[RIW-1:0]];
		if (ord_we) ord_mem[st_dec[RIW-1:0]] <= idx_q[RIW-1:0];
	end

	// Counters, error flag and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			known_cnt_q <= '0;
			row_cnt_q   <= '0;
			err_q       <= ERR_NONE;
			k_q         <= '0;
			v_s1        <= 1'b0;
			ch_q        <= '0;
			idx_q       <= '0;
			strobe_q    <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			// id scan over the known table, one entry a cycle
			if (cmd.cmd == CMD_LOAD) begin
				k_q  <= '0;
				v_s1 <= 1'b0;
			end else begin
				v_s1 <= scan_issue;
				if (scan_issue) k_q <= k_q + 1'b1;
			end
			if (add_new) known_cnt_q <= known_cnt_q + 1'b1;
			if (rc_we)   row_cnt_q   <= row_cnt_q + 1'b1;
			if (err_q == ERR_NONE && err_new != ERR_NONE) err_q <= err_new;
			unique case (cmd.cmd)
				CMD_EMIT_ERR: begin
					strobe_q  <= 1'b1;
					row_cnt_q <= '0;
					err_q     <= ERR_NONE;
				end
				CMD_DONE: begin
					row_cnt_q <= '0;
					err_q     <= ERR_NONE;
				end
				CMD_FIN_INIT: begin
					ch_q  <= '0;
					idx_q <= '0;
				end
				CMD_CLEAR: begin
					ch_q <= ch_last ? '0 : ch_q + 1'b1;
				end
				CMD_COUNT: begin
					if (cmd.ph == PH_C) idx_q <= idx_top ? '0 : idx_q + 1'b1;
				end
				CMD_PREFIX: begin
					if (cmd.ph == PH_B) begin
						if (ch_last) begin
							ch_q  <= '0;
							idx_q <= row_cnt_q - 1'b1;
						end else begin
							ch_q <= ch_q + 1'b1;
						end
					end
				end
				CMD_SCATTER: begin
					if (cmd.ph == PH_C) idx_q <= idx_zero ? '0 : idx_q - 1'b1;
				end
				CMD_OUTPUT: begin
					if (emit_row) begin
						strobe_q <= 1'b1;
						idx_q    <= idx_q + 1'b1;
						if (idx_top) row_cnt_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// Lookup accumulators, prefix accumulator and result payload
	always_ff @(posedge clk) begin
		if (cmd.cmd == CMD_LOAD) begin
			id_q   <= tablet_key;
			rank_q <= '0;
			hit_q  <= 1'b0;
		end else if (v_s1) begin
			if (kt_rd_q < id_q)       rank_q <= rank_q + 1'b1;
			else if (kt_rd_q == id_q) hit_q  <= 1'b1;
		end
		if (cmd.cmd == CMD_FIN_INIT) begin
			acc_q <= '0;
		end else if (cmd.cmd == CMD_PREFIX && cmd.ph == PH_B) begin
			acc_q <= st_sum;
		end
		if (cmd.cmd == CMD_EMIT_ERR) begin
			row_valid_q    <= 1'b0;
			row_index_q    <= '0;
			channel_rank_q <= '0;
			error_code_q   <= err_q;
			is_last_q      <= 1'b1;
		end else if (emit_row) begin
			row_valid_q    <= 1'b1;
			row_index_q    <= ROW_W'(ord_rd_q);
			channel_rank_q <= CHAN_W'(rc_rd_q);
			error_code_q   <= ERR_NONE;
			is_last_q      <= idx_top;
		end
	end

	assign result_strobe = strobe_q;
	assign row_valid     = row_valid_q;
	assign row_index     = row_index_q;
	assign channel_rank  = channel_rank_q;
	assign error_code    = error_code_q;
	assign is_last       = is_last_q;

endmodule

/* src/rpt_checker.sv */
// Port-level checks for the row partition block, bound to its top level.
// Depends on rpt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rpt_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic [rpt_pkg::OP_W-1:0]   operation,
	input logic                       result_strobe,
	input logic                       row_valid,
	input logic [rpt_pkg::ROW_W-1:0]  row_index,
	input logic [rpt_pkg::CHAN_W-1:0] channel_rank,
	input logic [rpt_pkg::ERR_W-1:0]  error_code,
	input logic                       is_last
);
	import rpt_pkg::*;

	logic add_or_append;
	logic err_fields_ok;
	assign add_or_append = start && !busy && operation != OP_FINISH;
	assign err_fields_ok = is_last && error_code != ERR_NONE && row_index == '0
		&& channel_rank == '0;

	// Row results never carry an error code
	`RPT_ASSERT_IMP(a_row_no_err, clk, arst_n, result_strobe && row_valid, error_code == ERR_NONE)

	// An error result stands alone: last, nonzero code, empty row fields
	`RPT_ASSERT_IMP(a_err_alone, clk, arst_n, result_strobe && !row_valid, err_fields_ok)

	// A row that is not last means the walk is still running
	`RPT_ASSERT_NXT(a_more_rows, clk, arst_n, result_strobe && !is_last, busy && !result_strobe)

	// Non-finish requests never produce a result
	`RPT_ASSERT_NXT(a_quiet_req, clk, arst_n, add_or_append, !result_strobe)

endmodule

bind row_partition_by_tablet rpt_checker u_rpt_checker (.*);

/* tb/row_partition_by_tablet_test.sv */
`timescale 1ns / 100ps
// Self-checking bench for row_partition_by_tablet: add, append and finish requests
// are checked against a stable per-channel grouping of each chunk's rows.
// Depends on rpt_pkg and the row_partition_by_tablet RTL.
module row_partition_by_tablet_test;
	import rpt_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int TABLET_SLOTS = MAX_TABLETS_DEF;
	localparam int ROW_SLOTS = MAX_ROWS_DEF;
	localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};
	localparam logic [ID_W-1:0] ID_MID = 63'h2AAA_AAAA_AAAA_AAAA;
	localparam logic [ID_W-1:0] ID_LOW = 63'h1555_5555_5555_5555;

	typedef struct packed {
		logic              row_valid;
		logic [ROW_W-1:0]  row_index;
		logic [CHAN_W-1:0] channel_rank;
		logic [ERR_W-1:0]  error_code;
		logic              is_last;
	} part_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [OP_W-1:0] operation = OP_ADD;
	logic [ID_W-1:0] tablet_key = '0;
	logic busy;
	logic result_strobe;
	logic row_valid;
	logic [ROW_W-1:0] row_index;
	logic [CHAN_W-1:0] channel_rank;
	logic [ERR_W-1:0] error_code;
	logic is_last;

	// Shadow state: known ids in load order, channel of each stored row, latched error
	logic [ID_W-1:0] known_ids[$];
	logic [CHAN_W-1:0] row_chan[$];
	logic [ERR_W-1:0] chunk_err = ERR_NONE;
	part_result_t rows_due[$];
	int fail_count = 0;
	int send_idle_pct = 33;

	row_partition_by_tablet dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.operation     (operation),
		.tablet_key    (tablet_key),
		.result_strobe (result_strobe),
		.row_valid     (row_valid),
		.row_index     (row_index),
		.channel_rank  (channel_rank),
		.error_code    (error_code),
		.is_last       (is_last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Rank of id among the known ids; returns 1 when the id is known
	function automatic bit find_channel(input logic [ID_W-1:0] id,
			output logic [CHAN_W-1:0] chan);
		int below;
		bit hit;
		below = 0;
		hit = 1'b0;
		foreach (known_ids[i]) begin
			if (known_ids[i] < id)
				below++;
			else if (known_ids[i] == id)
				hit = 1'b1;
		end
		chan = CHAN_W'(below);
		return hit;
	endfunction

	// Only the first error since the last finish is kept
	function automatic void latch_err(input logic [ERR_W-1:0] code);
		if (chunk_err == ERR_NONE)
			chunk_err = code;
	endfunction

	function automatic logic [ID_W-1:0] any_id();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[ID_W-1:0];
	endfunction

	function automatic logic [ID_W-1:0] known_id();
		if (known_ids.size() == 0)
			return any_id();
		return known_ids[$urandom_range(0, known_ids.size() - 1)];
	endfunction

	// Update the shadow state for one accepted request and queue what it must produce
	task automatic partition_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id);
		logic [CHAN_W-1:0] chan;
		part_result_t res;
		int left;
		unique case (op)
			OP_ADD: begin
				if (!find_channel(id, chan)) begin
					if (known_ids.size() >= TABLET_SLOTS)
						latch_err(ERR_TAB_FULL);
					else
						known_ids = {known_ids, id};
				end
			end
			OP_APPEND: begin
				if (row_chan.size() >= ROW_SLOTS) begin
					latch_err(ERR_ROWS_FULL);
				end else begin
					// unknown id still takes a row slot, parked on channel 0
					if (!find_channel(id, chan)) begin
						latch_err(ERR_UNKNOWN);
						chan = '0;
					end
					row_chan = {row_chan, chan};
				end
			end
			OP_FINISH: begin
				if (chunk_err != ERR_NONE) begin
					res = '{1'b0, {ROW_W{1'b0}}, {CHAN_W{1'b0}}, chunk_err, 1'b1};
					rows_due = {rows_due, res};
				end else begin
					// ascending channel, input order kept inside a channel
					left = row_chan.size();
					for (int c = 0; c < TABLET_SLOTS; c++) begin
						foreach (row_chan[r]) begin
							if (row_chan[r] == CHAN_W'(c)) begin
								left--;
								res.row_valid = 1'b1;
								res.row_index = ROW_W'(r);
								res.channel_rank = row_chan[r];
								res.error_code = ERR_NONE;
								res.is_last = (left == 0);
								rows_due = {rows_due, res};
							end
						end
					end
				end
				row_chan.delete();
				chunk_err = ERR_NONE;
			end
			default: ;
		endcase
	endtask

	// Present one request, hold it until accepted, then maybe idle a while
	task automatic issue_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id);
		start <= 1'b1;
		operation <= op;
		tablet_key <= id;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		partition_request(op, id);
		if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
			start <= 1'b0;
			if ($urandom_range(0, 7) == 0)
				repeat ($urandom_range(8, 40)) @(posedge clk);
			else
				repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// Hold off new requests until every queued result has been seen
	task automatic await_results();
		start <= 1'b0;
		do
			@(posedge clk);
		while (rows_due.size() != 0);
	endtask

	task automatic note_fault(input string what, input part_result_t want,
			input part_result_t got);
		if (fail_count < 10)
			$display("%0t %s: expected v=%0d row=%0d ch=%0d err=%0d last=%0d, got v=%0d row=%0d ch=%0d err=%0d last=%0d",
				$realtime, what, want.row_valid, want.row_index, want.channel_rank,
				want.error_code, want.is_last, got.row_valid, got.row_index,
				got.channel_rank, got.error_code, got.is_last);
		fail_count++;
	endtask

	// Result checker: each strobe is matched against the oldest queued result
	always @(posedge clk) begin : check_results
		part_result_t want;
		part_result_t got;
		if (arst_n && result_strobe) begin
			got = '{row_valid, row_index, channel_rank, error_code, is_last};
			if (rows_due.size() == 0) begin
				note_fault("unexpected result", '0, got);
			end else begin
				want = rows_due.pop_front();
				if (got.row_valid !== want.row_valid || got.row_index !== want.row_index
						|| got.channel_rank !== want.channel_rank
						|| got.error_code !== want.error_code
						|| got.is_last !== want.is_last)
					note_fault("result mismatch", want, got);
			end
		end
	end

	// Extremes, every operation, duplicates, unknown ids and late-added ids
	task automatic test_directed();
		issue_request(OP_FINISH, '0);        // empty chunk, nothing comes out
		issue_request(OP_UNUSED, ID_MAX);    // unused code is ignored
		issue_request(OP_APPEND, ID_MAX);    // nothing known yet
		issue_request(OP_FINISH, ID_MAX);
		issue_request(OP_ADD, ID_MAX);
		issue_request(OP_ADD, '0);
		issue_request(OP_ADD, '0);           // duplicate
		issue_request(OP_ADD, ID_MID);
		issue_request(OP_APPEND, ID_MAX);
		issue_request(OP_APPEND, '0);
		issue_request(OP_APPEND, ID_MID);
		issue_request(OP_APPEND, '0);
		issue_request(OP_APPEND, ID_MAX);
		issue_request(OP_FINISH, '0);
		await_results();
		// id added mid-chunk shifts the ranks of later rows only
		issue_request(OP_APPEND, ID_MID);
		issue_request(OP_ADD, ID_LOW);
		issue_request(OP_APPEND, ID_MID);
		issue_request(OP_APPEND, ID_LOW);
		issue_request(OP_FINISH, ID_LOW);
		// first error wins, later rows do not change it
		issue_request(OP_APPEND, 63'h123);
		issue_request(OP_APPEND, ID_MAX);
		issue_request(OP_FINISH, '0);
		issue_request(OP_APPEND, ID_MID);
		issue_request(OP_FINISH, ID_MAX);
	endtask

	// A full row store, then one row too many plus a later unknown id
	task automatic test_full_chunk();
		repeat (ROW_SLOTS) issue_request(OP_APPEND, known_id());
		issue_request(OP_FINISH, any_id());
		repeat (ROW_SLOTS + 1) issue_request(OP_APPEND, known_id());
		issue_request(OP_APPEND, any_id());
		issue_request(OP_FINISH, any_id());
		await_results();
	endtask

	// Fill the tablet table, overflow it, then use every channel
	task automatic test_table_full();
		while (known_ids.size() < TABLET_SLOTS)
			issue_request(OP_ADD, any_id());
		issue_request(OP_ADD, any_id());
		issue_request(OP_ADD, ID_MAX);       // duplicate on a full table
		issue_request(OP_APPEND, known_id());
		issue_request(OP_FINISH, any_id());
		for (int i = TABLET_SLOTS - 1; i >= 0; i--)
			issue_request(OP_APPEND, known_ids[i]);
		issue_request(OP_APPEND, known_ids[0]);
		issue_request(OP_FINISH, any_id());
		await_results();
	endtask

	// Mostly well-formed chunks of random length, with some noise mixed in
	task automatic test_random(input int idle_pct, input int n_items);
		int sent;
		int chunk_len;
		int roll;
		send_idle_pct = idle_pct;
		sent = 0;
		while (sent < n_items) begin
			roll = $urandom_range(0, 19);
			if (roll == 0)
				chunk_len = $urandom_range(60, 67);
			else if (roll < 4)
				chunk_len = $urandom_range(13, 40);
			else
				chunk_len = $urandom_range(1, 12);
			repeat (chunk_len) begin
				roll = $urandom_range(0, 99);
				if (roll < 86)
					issue_request(OP_APPEND, known_id());
				else if (roll < 88)
					issue_request(OP_APPEND, any_id());
				else if (roll < 93 && known_ids.size() < TABLET_SLOTS - 1)
					issue_request(OP_ADD, any_id());
				else if (roll < 96)
					issue_request(OP_ADD, known_id());
				else
					issue_request(OP_UNUSED, any_id());
				sent++;
			end
			issue_request(OP_FINISH, any_id());
			sent++;
			if ($urandom_range(0, 9) == 0)
				await_results();
		end
	endtask

	// Drain, settle, report
	task automatic finish_run();
		start <= 1'b0;
		for (int n = 0; n < 20000 && rows_due.size() != 0; n++)
			@(posedge clk);
		repeat (40) @(posedge clk);
		while (rows_due.size() != 0)
			note_fault("missing result", rows_due.pop_front(), '0);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_chunk();
		test_random(33, 120);
		test_table_full();
		test_random(57, 120);
		test_random(0, 120);
		finish_run();
	end

	// Watchdog
	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
